// File: rtl/throughput_core_count_governor_defines.svh
// assertion macros shared by the governor rtl
// no dependencies; included by the files that carry assertions
`ifndef THROUGHPUT_CORE_COUNT_GOVERNOR_DEFINES_SVH
`define THROUGHPUT_CORE_COUNT_GOVERNOR_DEFINES_SVH

// same-cycle implication
`define TCCG_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tccg assertion failed");

// next-cycle implication
`define TCCG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tccg assertion failed");

`endif

// File: rtl/tccg_pkg.sv
// shared types, constants and helpers of the core count governor
// no dependencies
package tccg_pkg;

   localparam int MAX_CORES_DEF = 64;
   localparam int RATE_BITS_DEF = 32;
   localparam int TIME_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CORE_W      = 7;   // core count registers and result
   localparam int CUR_W       = 8;   // reported core count
   localparam int CNT_W       = 8;   // window counters
   localparam int COOL_W      = 32;  // cooldown register
   localparam int RATIO_MAX_W = 25;  // ratio field carrier, widest fraction plus one
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [2:0] {
      REG_ENABLE       = 3'd0,
      REG_MIN_CORES    = 3'd1,
      REG_STARTUP      = 3'd2,
      REG_DROP_FRAC    = 3'd3,
      REG_RETAIN       = 3'd4,
      REG_DROP_NEED    = 3'd5,
      REG_STABLE_NEED  = 3'd6,
      REG_COOLDOWN     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic                   governor_enable;
      logic [CORE_W-1:0]      min_cores;
      logic [CORE_W-1:0]      startup_cores;
      logic [RATIO_MAX_W-1:0] drop_fraction;
      logic [RATIO_MAX_W-1:0] retain_ratio;
      logic [CNT_W-1:0]       drop_windows_needed;
      logic [CNT_W-1:0]       stable_windows_needed;
      logic [COOL_W-1:0]      cooldown_ticks;
   } cfg_type;

   // zero acts as one, values above the core limit act as the limit
   function automatic logic [CORE_W-1:0] core_reg(input logic [CORE_W-1:0] v,
                                                 input int unsigned max_c);
      logic [CORE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CORE_W'(1);
      end else if (int'(v) > int'(max_c)) begin
         r = CORE_W'(max_c);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
      return (v == '0) ? CNT_W'(1) : v;
   endfunction

endpackage

// File: rtl/tccg_if.sv
// valid/ready channel interfaces for samples and suggestions
// depends on tccg_pkg
interface tccg_req_if
   import tccg_pkg::*;
#(
   parameter int RATE_BITS = RATE_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [RATE_BITS-1:0] rate_sample;
   logic [CUR_W-1:0]     current_cores;
   logic [TIME_BITS-1:0] now_ticks;

   modport source (output valid, rate_sample, current_cores, now_ticks, input ready);
   modport sink (input valid, rate_sample, current_cores, now_ticks, output ready);
endinterface

interface tccg_rsp_if
   import tccg_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              adjust_valid;
   logic [CORE_W-1:0] new_cores;

   modport source (output valid, adjust_valid, new_cores, input ready);
   modport sink (input valid, adjust_valid, new_cores, output ready);
endinterface

// File: rtl/tccg_csr.sv
// apb-style configuration registers of the governor
// depends on tccg_pkg
module tccg_csr
   import tccg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);
   localparam int RW = FRAC_BITS + 1;

   logic              enable_ff;
   logic [CORE_W-1:0] min_ff;
   logic [CORE_W-1:0] startup_ff;
   logic [RW-1:0]     drop_ff;
   logic [RW-1:0]     retain_ff;
   logic [CNT_W-1:0]  drop_need_ff;
   logic [CNT_W-1:0]  stable_need_ff;
   logic [COOL_W-1:0] cool_ff;
   csr_idx_type       idx;
   logic              wr;

   assign pready = 1'b1;
   assign idx    = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         min_ff         <= CORE_W'(1);
         startup_ff     <= CORE_W'(64);
         drop_ff        <= '0;
         retain_ff      <= {1'b1, {FRAC_BITS{1'b0}}};
         drop_need_ff   <= CNT_W'(1);
         stable_need_ff <= CNT_W'(1);
         cool_ff        <= '0;
      end else if (wr) begin
         unique case (idx)
            REG_ENABLE:      enable_ff      <= pwdata[0];
            REG_MIN_CORES:   min_ff         <= pwdata[CORE_W-1:0];
            REG_STARTUP:     startup_ff     <= pwdata[CORE_W-1:0];
            REG_DROP_FRAC:   drop_ff        <= pwdata[RW-1:0];
            REG_RETAIN:      retain_ff      <= pwdata[RW-1:0];
            REG_DROP_NEED:   drop_need_ff   <= pwdata[CNT_W-1:0];
            REG_STABLE_NEED: stable_need_ff <= pwdata[CNT_W-1:0];
            REG_COOLDOWN:    cool_ff        <= pwdata[COOL_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ENABLE:      prdata = CSR_DATA_W'(enable_ff);
         REG_MIN_CORES:   prdata = CSR_DATA_W'(min_ff);
         REG_STARTUP:     prdata = CSR_DATA_W'(startup_ff);
         REG_DROP_FRAC:   prdata = CSR_DATA_W'(drop_ff);
         REG_RETAIN:      prdata = CSR_DATA_W'(retain_ff);
         REG_DROP_NEED:   prdata = CSR_DATA_W'(drop_need_ff);
         REG_STABLE_NEED: prdata = CSR_DATA_W'(stable_need_ff);
         REG_COOLDOWN:    prdata = CSR_DATA_W'(cool_ff);
      endcase
   end

   always_comb begin
      cfg.governor_enable       = enable_ff;
      cfg.min_cores             = min_ff;
      cfg.startup_cores         = startup_ff;
      cfg.drop_fraction         = RATIO_MAX_W'(drop_ff);
      cfg.retain_ratio          = RATIO_MAX_W'(retain_ff);
      cfg.drop_windows_needed   = drop_need_ff;
      cfg.stable_windows_needed = stable_need_ff;
      cfg.cooldown_ticks        = cool_ff;
   end

endmodule

// File: rtl/throughput_core_count_governor.sv
// top level of the throughput core count governor: sample pipeline and stage state
// depends on tccg_pkg, tccg_if, tccg_csr and the assertion macro header
//
// usage:
//  req_ch carries one throughput sample, the reported core count and a timestamp.
//  rsp_ch returns exactly one item per sample: adjust_valid with the suggested
//  core count, or adjust_valid low and new_cores zero.
//  the apb-style port holds eight registers at byte addresses 0 to 28; writes
//  take effect in the access phase, pready is tied high. write them while idle.
//  a sample accepted on req_ch passes one input register, then the evaluation
//  into the result register, before its result shows on rsp_ch.
//  throughput: one sample per cycle while rsp_ch is not held; the stage state
//  is updated in the same cycle that the result register loads, so the next
//  sample sees it at once; the two ratio multiplies and compares set the rate.
//  stall: while rsp_ch is held, the result stays and one more sample can wait
//  in the input register; req_ch.ready drops only when both are full.
//  reset: synchronous, clears the pipeline, the stage state and the registers
//  to their reset values; nothing is pending afterwards.
`include "throughput_core_count_governor_defines.svh"

module throughput_core_count_governor
   import tccg_pkg::*;
#(
   parameter int MAX_CORES = MAX_CORES_DEF,
   parameter int RATE_BITS = RATE_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tccg_req_if.sink              req_ch,
   tccg_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   localparam int RW    = FRAC_BITS + 1;
   localparam int PW    = RATE_BITS + RW;
   localparam int CMP_W = (TIME_BITS > COOL_W) ? TIME_BITS : COOL_W;
   localparam logic [RW-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   cfg_type cfg;

   tccg_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pipeline registers
   logic                 in_valid_ff;
   logic [RATE_BITS-1:0] in_rate_ff;
   logic [CUR_W-1:0]     in_cores_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_adj_ff;
   logic [CORE_W-1:0]    rsp_cores_ff;

   // stage state
   logic [CORE_W-1:0]    stage_cores_ff, stage_cores_in;
   logic [RATE_BITS-1:0] peak_ff, peak_in;
   logic [RATE_BITS-1:0] base_ff, base_in;
   logic [CNT_W-1:0]     drop_run_ff, drop_run_in;
   logic [CNT_W-1:0]     stable_run_ff, stable_run_in;
   logic                 skip_ff, skip_in;
   logic [TIME_BITS-1:0] last_adj_ff, last_adj_in;
   logic                 ever_ff, ever_in;
   logic                 adj_in;
   logic [CORE_W-1:0]    new_cores_in;

   logic                 out_free;
   logic                 fire;
   logic [CORE_W-1:0]    hi, lo_raw, lo, cur;
   logic [RW-1:0]        drop_sat, keep_sat, one_minus_drop;
   logic [CNT_W-1:0]     need_drop, need_stable;
   logic [RATE_BITS-1:0] peak_max;
   logic [PW-1:0]        drop_lhs, drop_rhs, stab_lhs, stab_rhs;
   logic                 is_drop, is_stable;
   logic [CNT_W-1:0]     drop_run_upd, stable_run_upd;
   logic [TIME_BITS-1:0] since_adj;
   logic                 cooling;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.adjust_valid = rsp_adj_ff;
   assign rsp_ch.new_cores    = rsp_cores_ff;

   // effective limits from the registers
   always_comb begin
      hi       = core_reg(cfg.startup_cores, MAX_CORES);
      lo_raw   = core_reg(cfg.min_cores, MAX_CORES);
      lo       = (lo_raw > hi) ? hi : lo_raw;
      drop_sat = (cfg.drop_fraction[RW-1:0] > FX_ONE) ? FX_ONE : cfg.drop_fraction[RW-1:0];
      keep_sat = (cfg.retain_ratio[RW-1:0] > FX_ONE) ? FX_ONE : cfg.retain_ratio[RW-1:0];
      one_minus_drop = FX_ONE - drop_sat;
      need_drop      = at_least_one(cfg.drop_windows_needed);
      need_stable    = at_least_one(cfg.stable_windows_needed);
   end

   // window evaluation on the held sample
   always_comb begin
      if (in_cores_ff < {1'b0, lo}) begin
         cur = lo;
      end else if (in_cores_ff > {1'b0, hi}) begin
         cur = hi;
      end else begin
         cur = in_cores_ff[CORE_W-1:0];
      end
      peak_max = (in_rate_ff > peak_ff) ? in_rate_ff : peak_ff;
      // exact products, sample scaled by one against the scaled references
      drop_lhs = {in_rate_ff, {FRAC_BITS{1'b0}}, 1'b0} >> 1;
      drop_rhs = {{RW{1'b0}}, peak_max} * {{RATE_BITS{1'b0}}, one_minus_drop};
      stab_lhs = {{RW{1'b0}}, base_ff} * {{RATE_BITS{1'b0}}, keep_sat};
      stab_rhs = drop_lhs;
      is_drop   = (cur > lo) && (drop_lhs <= drop_rhs);
      is_stable = (cur < hi) && (stab_lhs <= stab_rhs);
      drop_run_upd   = !is_drop ? '0 :
                       ((drop_run_ff == CNT_MAX) ? drop_run_ff : drop_run_ff + CNT_W'(1));
      stable_run_upd = !is_stable ? '0 :
                       ((stable_run_ff == CNT_MAX) ? stable_run_ff : stable_run_ff + CNT_W'(1));
      since_adj = in_now_ff - last_adj_ff;
      cooling   = ever_ff && (CMP_W'(since_adj) < CMP_W'(cfg.cooldown_ticks));
   end

   always_comb begin
      stage_cores_in = stage_cores_ff;
      peak_in        = peak_ff;
      base_in        = base_ff;
      drop_run_in    = drop_run_ff;
      stable_run_in  = stable_run_ff;
      skip_in        = skip_ff;
      last_adj_in    = last_adj_ff;
      ever_in        = ever_ff;
      adj_in         = 1'b0;
      new_cores_in   = '0;
      priority if (!cfg.governor_enable || in_rate_ff == '0) begin
         // sample ignored
      end else if (stage_cores_ff != cur || base_ff == '0 && !skip_ff) begin
         // new stage or empty baseline
         stage_cores_in = cur;
         peak_in        = in_rate_ff;
         base_in        = in_rate_ff;
         drop_run_in    = '0;
         stable_run_in  = '0;
         skip_in        = 1'b0;
      end else if (skip_ff) begin
         skip_in = 1'b0;
      end else if (!cooling && (drop_run_upd >= need_drop || stable_run_upd >= need_stable)) begin
         adj_in         = 1'b1;
         new_cores_in   = (drop_run_upd >= need_drop) ? cur - CORE_W'(1) : cur + CORE_W'(1);
         stage_cores_in = new_cores_in;
         peak_in        = '0;
         base_in        = '0;
         drop_run_in    = '0;
         stable_run_in  = '0;
         skip_in        = 1'b1;
         last_adj_in    = in_now_ff;
         ever_in        = 1'b1;
      end else begin
         peak_in       = peak_max;
         drop_run_in   = drop_run_upd;
         stable_run_in = stable_run_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         stage_cores_ff <= '0;
         peak_ff        <= '0;
         base_ff        <= '0;
         drop_run_ff    <= '0;
         stable_run_ff  <= '0;
         skip_ff        <= 1'b0;
         last_adj_ff    <= '0;
         ever_ff        <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            stage_cores_ff <= stage_cores_in;
            peak_ff        <= peak_in;
            base_ff        <= base_in;
            drop_run_ff    <= drop_run_in;
            stable_run_ff  <= stable_run_in;
            skip_ff        <= skip_in;
            last_adj_ff    <= last_adj_in;
            ever_ff        <= ever_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_rate_ff  <= req_ch.rate_sample;
         in_cores_ff <= req_ch.current_cores;
         in_now_ff   <= req_ch.now_ticks;
      end
      if (fire) begin
         rsp_adj_ff   <= adj_in;
         rsp_cores_ff <= new_cores_in;
      end
   end

   `TCCG_ASSERT_NOW(a_idle_result_zero, clock, reset,
      rsp_valid_ff && !rsp_adj_ff, rsp_cores_ff == '0)
   `TCCG_ASSERT_NOW(a_adjust_nonzero, clock, reset,
      rsp_valid_ff && rsp_adj_ff, rsp_cores_ff != '0)
   `TCCG_ASSERT_NOW(a_skip_means_empty_stage, clock, reset,
      skip_ff, base_ff == '0 && peak_ff == '0 && drop_run_ff == '0)
   `TCCG_ASSERT_NEXT(a_adjust_marks_state, clock, reset,
      fire && adj_in, ever_ff && skip_ff && rsp_valid_ff && rsp_adj_ff)

endmodule
